// File: design/aebb_pkg.sv
// ----------------------------------------------------------------------------
// Area-effect bounding box package
// Shape codes, the item record passed from front to back, the quarter-wave
// sine table and the heading lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package aebb_pkg;

    // quarter-wave table
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_W           = 15;
    localparam int TAB_IDX_W        = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int LUT_PROD_W       = 14 + TAB_IDX_W;

    // item field widths
    localparam int SIZE_W = 20;
    localparam int POS_W  = 24;
    localparam int HALF_W = 21;
    localparam int HEAD_W = 16;
    localparam int MUL_W  = SIZE_W + SINE_W;
    localparam int OFF_W  = MUL_W + 2 - 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // shape codes as they arrive
    localparam logic [2:0] SHAPE_CIRCLE = 3'd0;
    localparam logic [2:0] SHAPE_RECT   = 3'd1;
    localparam logic [2:0] SHAPE_SECTOR = 3'd2;
    localparam logic [2:0] SHAPE_PROJ   = 3'd3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        KIND_CIRCLE,
        KIND_RECT,
        KIND_SECTOR,
        KIND_PROJ,
        KIND_NONE
    } t_kind;

    typedef struct packed {
        logic [SINE_W-1:0] mag;
        logic              neg;
    } t_trig;

    typedef struct packed {
        t_kind                    kind;
        logic [SIZE_W-1:0]        rad;
        logic [SIZE_W-1:0]        wid;
        logic [SIZE_W-1:0]        hgt;
        logic [SIZE_W-1:0]        rch;
        logic signed [POS_W-1:0]  ox;
        logic signed [POS_W-1:0]  oy;
        t_trig                    sin_v;
        t_trig                    cos_v;
    } t_job;

    typedef logic [SINE_W-1:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    // Taylor series of sin in Q2.30, eight terms, scaled to unsigned Q0.15
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] ent;
        longint      sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            ent = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
            if (ent > 64'd32767) begin
                ent = 64'd32767;
            end
            tab[i] = ent[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    // sine of a binary angle: magnitude from the table, sign from the half turn
    function automatic t_trig trig_lookup(input logic [HEAD_W-1:0] h);
        logic [LUT_PROD_W-1:0] prod;
        logic [TAB_IDX_W-1:0]  idx;
        logic [TAB_IDX_W-1:0]  addr;
        t_trig                 r;
        prod  = LUT_PROD_W'(h[13:0]) * LUT_PROD_W'(SINE_TABLE_DEPTH);
        idx   = prod[LUT_PROD_W-1:14];
        addr  = h[14] ? (TAB_IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
        r.mag = SINE_TAB[addr];
        r.neg = h[15];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/area_effect_bounding_box_top.sv
// ----------------------------------------------------------------------------
// Area-effect bounding box
// Turns one area effect (shape, sizes, origin, heading) into one
// axis-aligned box given as a centre and two half extents.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | i_valid / o_stall  | shape, radius, width, height,
//           |           |                    | reach, origin x/y, heading
//   result  | out       | o_valid / i_stall  | centre x/y, half width/height
//
// One item per cycle while i_stall is low; an item passes the front register,
// the queue, the product stage, the rounding stage and the output register.
// The rate is set by the back end's product stage: six 20x15 multipliers
// working in parallel on every item.
// Reset is synchronous and active low; it empties the queue and the stages.
// The sine table is constant and needs no fill after reset.
// The input stalls only when the front register holds an item and the
// four-entry queue is full; the back end holds each stage while downstream
// stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module area_effect_bounding_box_top import aebb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [2:0]               i_aoe_shape,
    input  wire logic [SIZE_W-1:0]        i_radius_in,
    input  wire logic [SIZE_W-1:0]        i_rect_width,
    input  wire logic [SIZE_W-1:0]        i_rect_height,
    input  wire logic [SIZE_W-1:0]        i_reach,
    input  wire logic signed [POS_W-1:0]  i_origin_x,
    input  wire logic signed [POS_W-1:0]  i_origin_y,
    input  wire logic [HEAD_W-1:0]        i_heading,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [POS_W-1:0]       o_center_x,
    output logic signed [POS_W-1:0]       o_center_y,
    output logic [HALF_W-1:0]             o_half_width,
    output logic [HALF_W-1:0]             o_half_height
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job front_job;
    t_job q_job;

    aebb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_aoe_shape   (i_aoe_shape),
        .i_radius_in   (i_radius_in),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_reach       (i_reach),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_heading     (i_heading),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (front_job)
    );

    aebb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_job)
    );

    aebb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_center_x    (o_center_x),
        .o_center_y    (o_center_y),
        .o_half_width  (o_half_width),
        .o_half_height (o_half_height)
    );

endmodule

`default_nettype wire

// File: design/aebb_front.sv
// ----------------------------------------------------------------------------
// Area-effect bounding box front end
// Takes items, classifies the shape code and looks up sine and cosine of
// the heading, then hands the record to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aebb_front import aebb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [2:0]               i_aoe_shape,
    input  wire logic [SIZE_W-1:0]        i_radius_in,
    input  wire logic [SIZE_W-1:0]        i_rect_width,
    input  wire logic [SIZE_W-1:0]        i_rect_height,
    input  wire logic [SIZE_W-1:0]        i_reach,
    input  wire logic signed [POS_W-1:0]  i_origin_x,
    input  wire logic signed [POS_W-1:0]  i_origin_y,
    input  wire logic [HEAD_W-1:0]        i_heading,
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output t_job                          o_job
);

    logic  r_valid;
    t_job  r_job;
    t_job  n_job;
    t_kind n_kind;
    logic  load;

    always_comb begin
        unique case (i_aoe_shape)
            SHAPE_CIRCLE: n_kind = KIND_CIRCLE;
            SHAPE_RECT:   n_kind = KIND_RECT;
            SHAPE_SECTOR: n_kind = KIND_SECTOR;
            SHAPE_PROJ:   n_kind = KIND_PROJ;
            default:      n_kind = KIND_NONE;
        endcase
    end

    always_comb begin
        n_job.kind  = n_kind;
        n_job.rad   = i_radius_in;
        n_job.wid   = i_rect_width;
        n_job.hgt   = i_rect_height;
        n_job.rch   = i_reach;
        n_job.ox    = i_origin_x;
        n_job.oy    = i_origin_y;
        n_job.sin_v = trig_lookup(i_heading);
        // cosine is the sine a quarter turn on
        n_job.cos_v = trig_lookup(i_heading + HEAD_W'(16384));
    end

    // hold the record while the queue is full
    assign load    = !r_valid || !i_q_full;
    assign o_stall = !load;
    assign o_push  = r_valid && !i_q_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// File: design/aebb_fifo.sv
// ----------------------------------------------------------------------------
// Area-effect bounding box queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module aebb_fifo import aebb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_data,
    output logic       o_full,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_job       o_data
);

    t_job              r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("queue count lost a write");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: design/aebb_back.sv
// ----------------------------------------------------------------------------
// Area-effect bounding box back end
// Three stages: products, rounding and extents, then centre and saturation
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aebb_back import aebb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire t_job                     i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [POS_W-1:0]       o_center_x,
    output logic signed [POS_W-1:0]       o_center_y,
    output logic [HALF_W-1:0]             o_half_width,
    output logic [HALF_W-1:0]             o_half_height
);

    typedef struct packed {
        t_kind                   kind;
        logic [SIZE_W-1:0]       rad;
        logic [SIZE_W-1:0]       rch;
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic                    cos_neg;
        logic                    sin_neg;
        logic [MUL_W-1:0]        p_rc;
        logic [MUL_W-1:0]        p_rs;
        logic [MUL_W-1:0]        p_wc;
        logic [MUL_W-1:0]        p_hs;
        logic [MUL_W-1:0]        p_ws;
        logic [MUL_W-1:0]        p_hc;
    } t_mul;

    typedef struct packed {
        t_kind                   kind;
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic [OFF_W-1:0]        off_x;
        logic [OFF_W-1:0]        off_y;
        logic [HALF_W-1:0]       hw;
        logic [HALF_W-1:0]       hh;
    } t_rnd;

    localparam int SUM_W = MUL_W + 2;
    localparam int EXT_W = MUL_W + 1;
    localparam int CEN_W = POS_W + 1;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    t_mul r_s1;
    t_mul n_s1;
    t_rnd r_s2;
    t_rnd n_s2;

    logic [SUM_W-1:0]  sx;
    logic [SUM_W-1:0]  sy;
    logic [EXT_W-1:0]  ext_w;
    logic [EXT_W-1:0]  ext_h;
    logic [SIZE_W+1:0] proj;

    logic [POS_W-1:0]  n_cx;
    logic [POS_W-1:0]  n_cy;

    // clamp a 25-bit sum into the 24-bit signed range
    function automatic logic [POS_W-1:0] sat_pos(input logic [CEN_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v[CEN_W-1] != v[CEN_W-2]) begin
            r = v[CEN_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    assign rdy3  = !r_v3 || !i_stall;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign o_pop = i_q_valid && rdy1;

    // stage 1: products
    always_comb begin
        n_s1.kind    = i_job.kind;
        n_s1.rad     = i_job.rad;
        n_s1.rch     = i_job.rch;
        n_s1.ox      = i_job.ox;
        n_s1.oy      = i_job.oy;
        n_s1.cos_neg = i_job.cos_v.neg;
        n_s1.sin_neg = i_job.sin_v.neg;
        n_s1.p_rc    = MUL_W'(i_job.rch) * MUL_W'(i_job.cos_v.mag);
        n_s1.p_rs    = MUL_W'(i_job.rch) * MUL_W'(i_job.sin_v.mag);
        n_s1.p_wc    = MUL_W'(i_job.wid) * MUL_W'(i_job.cos_v.mag);
        n_s1.p_hs    = MUL_W'(i_job.hgt) * MUL_W'(i_job.sin_v.mag);
        n_s1.p_ws    = MUL_W'(i_job.wid) * MUL_W'(i_job.sin_v.mag);
        n_s1.p_hc    = MUL_W'(i_job.hgt) * MUL_W'(i_job.cos_v.mag);
    end

    // stage 2: signed offsets rounded half up, half extents per shape
    always_comb begin
        sx = r_s1.cos_neg ? (SUM_W'(0) - SUM_W'(r_s1.p_rc)) : SUM_W'(r_s1.p_rc);
        sy = r_s1.sin_neg ? (SUM_W'(0) - SUM_W'(r_s1.p_rs)) : SUM_W'(r_s1.p_rs);
        sx = sx + SUM_W'(32768);
        sy = sy + SUM_W'(32768);
        ext_w = EXT_W'(r_s1.p_wc) + EXT_W'(r_s1.p_hs) + EXT_W'(32768);
        ext_h = EXT_W'(r_s1.p_ws) + EXT_W'(r_s1.p_hc) + EXT_W'(32768);
        proj  = (SIZE_W + 2)'(r_s1.rch) + {1'b0, r_s1.rad, 1'b0} + (SIZE_W + 2)'(1);

        n_s2.kind  = r_s1.kind;
        n_s2.ox    = r_s1.ox;
        n_s2.oy    = r_s1.oy;
        n_s2.off_x = sx[SUM_W-1:16];
        n_s2.off_y = sy[SUM_W-1:16];
        unique case (r_s1.kind)
            KIND_CIRCLE: begin
                n_s2.hw = HALF_W'(r_s1.rad);
                n_s2.hh = HALF_W'(r_s1.rad);
            end
            KIND_SECTOR: begin
                n_s2.hw = HALF_W'(r_s1.rch);
                n_s2.hh = HALF_W'(r_s1.rch);
            end
            KIND_RECT: begin
                n_s2.hw = HALF_W'(ext_w[EXT_W-1:16]);
                n_s2.hh = HALF_W'(ext_h[EXT_W-1:16]);
            end
            KIND_PROJ: begin
                n_s2.hw = proj[SIZE_W+1:1];
                n_s2.hh = proj[SIZE_W+1:1];
            end
            default: begin
                n_s2.hw = '0;
                n_s2.hh = '0;
            end
        endcase
    end

    // stage 3: push the centre forward for rectangles and projectiles
    always_comb begin
        if (r_s2.kind == KIND_RECT || r_s2.kind == KIND_PROJ) begin
            n_cx = sat_pos({r_s2.ox[POS_W-1], r_s2.ox}
                         + {{(CEN_W-OFF_W){r_s2.off_x[OFF_W-1]}}, r_s2.off_x});
            n_cy = sat_pos({r_s2.oy[POS_W-1], r_s2.oy}
                         + {{(CEN_W-OFF_W){r_s2.off_y[OFF_W-1]}}, r_s2.off_y});
        end else begin
            n_cx = r_s2.ox;
            n_cy = r_s2.oy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_q_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_v2) begin
            o_center_x    <= n_cx;
            o_center_y    <= n_cy;
            o_half_width  <= r_s2.hw;
            o_half_height <= r_s2.hh;
        end
    end

    assign o_valid = r_v3;

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && rdy3) |=> r_v3)
        else $error("item dropped between rounding and output");

    a_no_pop_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && i_stall) |-> !o_pop)
        else $error("queue read while every stage is held");

    a_hold_full_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !rdy2) |=> r_v1)
        else $error("held product stage lost its item");

endmodule

`default_nettype wire
